// File: rtl/tekd_pkg.sv
// Shared types and constants for the terminal escape key decoder.
// Holds the phase codes, key codes, character constants and the state and result structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tekd_pkg;

  // Parse phase codes.
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_AFTER_ESC = 4'd1;
  localparam logic [3:0] PH_PREFIXED  = 4'd2;
  localparam logic [3:0] PH_SWALLOW   = 4'd3;
  localparam logic [3:0] PH_ONE       = 4'd4;
  localparam logic [3:0] PH_ONE_FIVE  = 4'd5;
  localparam logic [3:0] PH_FORM_END  = 4'd6;
  localparam logic [3:0] PH_MOUSE_B   = 4'd7;
  localparam logic [3:0] PH_MOUSE_C   = 4'd8;
  localparam logic [3:0] PH_MOUSE_R   = 4'd9;

  // Key codes.
  localparam logic [3:0] K_PLAIN   = 4'd0;
  localparam logic [3:0] K_ESC     = 4'd1;
  localparam logic [3:0] K_UP      = 4'd2;
  localparam logic [3:0] K_DOWN    = 4'd3;
  localparam logic [3:0] K_LEFT    = 4'd4;
  localparam logic [3:0] K_RIGHT   = 4'd5;
  localparam logic [3:0] K_PGUP    = 4'd6;
  localparam logic [3:0] K_PGDN    = 4'd7;
  localparam logic [3:0] K_HOME    = 4'd8;
  localparam logic [3:0] K_END     = 4'd9;
  localparam logic [3:0] K_INS     = 4'd10;
  localparam logic [3:0] K_DEL     = 4'd11;
  localparam logic [3:0] K_MOUSE   = 4'd12;
  localparam logic [3:0] K_UNKNOWN = 4'd13;

  // Character constants.
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_O      = 8'h4F;  // 'O'
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CH_BANG   = 8'h21;  // '!'
  localparam logic [7:0] CH_M      = 8'h4D;  // 'M'
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_4      = 8'h34;
  localparam logic [7:0] CH_5      = 8'h35;
  localparam logic [7:0] CH_6      = 8'h36;
  localparam logic [7:0] CH_0      = 8'h30;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] wait_cnt;
    logic [3:0]  pending_key;
    logic [7:0]  second_digit;
    logic [8:0]  mouse_button;
    logic [8:0]  mouse_column;
  } tekd_state_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  key_code;
    logic [7:0]  plain_byte;
    logic [8:0]  mouse_button;
    logic [8:0]  mouse_column;
    logic [8:0]  mouse_row;
  } tekd_result_t;

endpackage

`default_nettype wire

// File: rtl/tekd_step.sv
// Next-state and result logic of the escape key decoder for one byte or tick.
// Purely combinational; depends on tekd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tekd_step
  import tekd_pkg::*;
(
  input  wire tekd_state_t  state,
  input  wire logic         mode,
  input  wire logic [7:0]   data_byte,
  input  wire logic [15:0]  timeout,
  output tekd_state_t       state_nxt,
  output tekd_result_t      result
);

  logic [15:0] cnt_inc;
  logic [3:0]  letter_key;

  // Key selected by a letter after ESC or the prefix.
  always_comb begin
    case (data_byte)
      8'h41, 8'h69:              letter_key = K_UP;     // 'A' 'i'
      8'h42:                     letter_key = K_DOWN;   // 'B'
      8'h44:                     letter_key = K_LEFT;   // 'D'
      8'h43:                     letter_key = K_RIGHT;  // 'C'
      8'h49, 8'h56, 8'h53, 8'h76: letter_key = K_PGUP;  // 'I' 'V' 'S' 'v'
      8'h47, 8'h55, 8'h54:       letter_key = K_PGDN;   // 'G' 'U' 'T'
      8'h48:                     letter_key = K_HOME;   // 'H'
      8'h46, 8'h59:              letter_key = K_END;    // 'F' 'Y'
      default:                   letter_key = K_UNKNOWN;
    endcase
  end

  assign cnt_inc = (state.wait_cnt != CNT_MAX) ? state.wait_cnt + 16'd1 : state.wait_cnt;

  always_comb begin
    state_nxt = state;
    result    = '0;
    if (mode) begin
      // Ticks only count while waiting for the byte after ESC.
      if (state.phase == PH_AFTER_ESC) begin
        state_nxt.wait_cnt = cnt_inc;
        if (cnt_inc >= timeout) begin
          result.valid      = 1'b1;
          result.key_code   = K_ESC;
          result.plain_byte = CH_ESC;
          state_nxt.phase   = PH_IDLE;
        end
      end
    end else begin
      unique case (state.phase)
        PH_IDLE: begin
          if (data_byte == CH_ESC) begin
            state_nxt.phase    = PH_AFTER_ESC;
            state_nxt.wait_cnt = '0;
          end else begin
            result.valid      = 1'b1;
            result.key_code   = K_PLAIN;
            result.plain_byte = data_byte;
          end
        end
        PH_AFTER_ESC, PH_PREFIXED: begin
          if (state.phase == PH_AFTER_ESC &&
              (data_byte == CH_LBRACK || data_byte == CH_O)) begin
            state_nxt.phase = PH_PREFIXED;
          end else begin
            state_nxt.phase = PH_IDLE;
            case (data_byte)
              CH_2: begin
                state_nxt.pending_key = K_INS;
                state_nxt.phase       = PH_SWALLOW;
              end
              CH_3: begin
                state_nxt.pending_key = K_DEL;
                state_nxt.phase       = PH_SWALLOW;
              end
              CH_4: begin
                state_nxt.pending_key = K_END;
                state_nxt.phase       = PH_SWALLOW;
              end
              CH_5: begin
                state_nxt.pending_key = K_PGUP;
                state_nxt.phase       = PH_SWALLOW;
              end
              CH_6: begin
                state_nxt.pending_key = K_PGDN;
                state_nxt.phase       = PH_SWALLOW;
              end
              CH_1: state_nxt.phase = PH_ONE;
              CH_M: state_nxt.phase = PH_MOUSE_B;
              default: begin
                result.valid    = 1'b1;
                result.key_code = letter_key;
              end
            endcase
          end
        end
        PH_SWALLOW: begin
          result.valid    = 1'b1;
          result.key_code = state.pending_key;
          state_nxt.phase = PH_IDLE;
        end
        PH_ONE: begin
          if (data_byte == CH_5) begin
            state_nxt.phase = PH_ONE_FIVE;
          end else begin
            result.valid    = 1'b1;
            result.key_code = K_HOME;
            state_nxt.phase = PH_IDLE;
          end
        end
        PH_ONE_FIVE: begin
          state_nxt.second_digit = data_byte;
          state_nxt.phase        = PH_FORM_END;
        end
        PH_FORM_END: begin
          result.valid = 1'b1;
          if (state.second_digit == CH_0) begin
            result.key_code = K_PGUP;
          end else if (state.second_digit == CH_4) begin
            result.key_code = K_PGDN;
          end else begin
            result.key_code = K_HOME;
          end
          state_nxt.phase = PH_IDLE;
        end
        PH_MOUSE_B: begin
          state_nxt.mouse_button = {1'b0, data_byte} - {1'b0, CH_SPACE};
          state_nxt.phase        = PH_MOUSE_C;
        end
        PH_MOUSE_C: begin
          state_nxt.mouse_column = {1'b0, data_byte} - {1'b0, CH_BANG};
          state_nxt.phase        = PH_MOUSE_R;
        end
        PH_MOUSE_R: begin
          result.valid        = 1'b1;
          result.key_code     = K_MOUSE;
          result.mouse_button = state.mouse_button;
          result.mouse_column = state.mouse_column;
          result.mouse_row    = {1'b0, data_byte} - {1'b0, CH_BANG};
          state_nxt.phase     = PH_IDLE;
        end
        default: begin
          state_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/terminal_escape_key_decoder_top.sv
// Top level of the terminal escape key decoder: input register, phase state, result register.
// Depends on tekd_pkg and tekd_step.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one word per cycle while in_tready is high, either a received terminal
// byte (tuser 0) or one timer tick (tuser 1), and returns at most one decoded key word for
// it. Throughput is one word per clock while the output is not stalled. A word passes the input
// register, the combinational phase logic and the result register. The result register lets a
// new word enter while a finished key waits to be taken. The escape timeout is written through
// cfg_wr_en and cfg_wr_data and should only change while no sequence is in progress.
module terminal_escape_key_decoder_top
  import tekd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] key_code, [11:4] plain_byte, [20:12] mouse_button, [29:21] mouse_column,
  // [38:30] mouse_row, [39] zero
  output logic [39:0]      out_tdata
);

  logic [15:0]  timeout_r;
  logic         in_valid_r;
  logic         in_mode_r;
  logic [7:0]   in_byte_r;
  tekd_state_t  state_r;
  tekd_state_t  state_nxt;
  tekd_result_t step_res;
  logic         out_valid_r;
  tekd_result_t out_res_r;
  logic         consume;

  assign consume   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser[0];
      in_byte_r <= in_tdata;
    end
  end

  tekd_step u_step (
    .state     (state_r),
    .mode      (in_mode_r),
    .data_byte (in_byte_r),
    .timeout   (timeout_r),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (consume) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (consume) begin
      out_valid_r <= step_res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.mouse_row, out_res_r.mouse_column,
                       out_res_r.mouse_button, out_res_r.plain_byte, out_res_r.key_code};

  // The mouse fields carry data only in a mouse result.
  a_mouse_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.key_code != K_MOUSE |->
      out_res_r.mouse_button == '0 && out_res_r.mouse_column == '0 &&
      out_res_r.mouse_row == '0)
    else $error("mouse fields set in a non-mouse result");

  // A tick outside the wait after ESC leaves the parser untouched.
  a_tick_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_mode_r && state_r.phase != PH_AFTER_ESC |=> state_r == $past(state_r))
    else $error("ignored tick changed the parser state");

  // A tick never yields a key other than the lone escape.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_mode_r && step_res.valid |-> step_res.key_code == K_ESC)
    else $error("tick produced a key other than escape");

  // Every emitted key returns the parser to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    consume && step_res.valid |=> state_r.phase == PH_IDLE)
    else $error("parser not idle after a result");

endmodule

`default_nettype wire
